[hdl/srb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and constants of the stratified ring bank refresh block.
// ----------------------------------------------------------------------------
package srb_pkg;

	// Strata and per-stratum state geometry.
	localparam int NUM_STRATA = 3;
	localparam int ST_ENTRIES = 4;
	localparam int ST_AW      = 2;

	// Field widths.
	localparam int CAP_W   = 11;
	localparam int CUR_W   = 10;
	localparam int DEBT_W  = 27;
	localparam int FRAC_W  = 24;
	localparam int GRANT_W = 16;
	localparam int WORD_W  = 32;
	localparam int SLOT_W  = 10;
	localparam int SUM_W   = 12;
	localparam int IN_GOALS = 6;

	localparam logic [CAP_W-1:0] CAP_MAX = 11'd1024;

	// Request kinds carried on tuser.
	localparam logic REQ_OPEN = 1'b0;
	localparam logic REQ_CAND = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] CFG_CAP_OFF = 2'd0;
	localparam logic [1:0] CFG_CAP_DEF = 2'd1;
	localparam logic [1:0] CFG_CAP_RES = 2'd2;
	localparam logic [1:0] CFG_FRAC    = 2'd3;

	// Stratum code that selects no stratum.
	localparam logic [1:0] STRATUM_NONE = 2'd3;

	// Input word layout, lowest bit first.
	localparam int IN_SEL_LSB   = 0;
	localparam int IN_OFFER_LSB = 2;
	localparam int IN_STAMP_LSB = 18;
	localparam int IN_GOAL_LSB  = 50;
	localparam int IN_VAL_LSB   = 242;
	localparam int IN_PRES_BIT  = 274;
	localparam int IN_TDATA_W   = 280;
	localparam int OUT_TDATA_W  = 88;

	// One entry of the per-stratum state memory.
	typedef struct packed {
		logic [DEBT_W-1:0] debt;
		logic [CAP_W-1:0]  count;
		logic [CUR_W-1:0]  cursor;
	} strat_ent_t;

	// One result word without the bank fill, which is taken at load time.
	typedef struct packed {
		logic [CAP_W-1:0]   sfill;
		logic [WORD_W-1:0]  stored;
		logic [SLOT_W-1:0]  slot;
		logic               written;
		logic [GRANT_W-1:0] granted;
	} res_t;

	// Capacity as used: zero acts as one, anything above the maximum is clipped.
	function automatic logic [CAP_W-1:0] eff_cap(input logic [CAP_W-1:0] c);
		logic [CAP_W-1:0] r;
		r = c;
		if (c == '0) begin
			r = 11'd1;
		end else if (c > CAP_MAX) begin
			r = CAP_MAX;
		end
		return r;
	endfunction

endpackage

[hdl/stratified_ring_bank_refresh.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stratified_ring_bank_refresh
// Three circular strata of goal slots refreshed by quota; candidates are
// written at the stratum cursor until the granted count is used up.
// ----------------------------------------------------------------------------
// Results load the output register from the read state for a dropped candidate
// or an open of no stratum, from the open state for an open and from the slot
// state for a stored one. A word is taken only when idle, after the last result
// is in the output register, after the state memory read-modify-write and the
// slot address reduction (reciprocal multiply). Reset restores the defaults of
// the configuration and clears cursors, counts, debts, but not the slot store.
module stratified_ring_bank_refresh
	import srb_pkg::*;
#(
	parameter int BANK_SIZE  = 1024,
	parameter int GOAL_WORDS = 6
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// tdata: stratum_sel, offered_count, iteration_stamp, goal_word_0..5,
	// value_bits, value_present, zero fill.
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// tuser: req_type.
	input  logic                   s_axis_tuser,
	// Output stream.
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// tdata: granted, written, slot_index, stored_value, stratum_fill,
	// bank_fill, zero fill.
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// Configuration write port.
	input  logic                   cfg_we,
	input  logic [1:0]             cfg_addr,
	input  logic [FRAC_W-1:0]      cfg_data
);

	localparam int AW     = $clog2(BANK_SIZE);
	localparam int ROW_W  = GOAL_WORDS * WORD_W + 2 * WORD_W;
	localparam longint unsigned RECIP_L = ((64'd1 << 32) + BANK_SIZE - 1) / BANK_SIZE;
	localparam logic [31:0] RECIP = 32'(RECIP_L);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_READ = 3'd1;
	localparam logic [2:0] ST_OPEN = 3'd2;
	localparam logic [2:0] ST_QUOT = 3'd3;
	localparam logic [2:0] ST_SLOT = 3'd4;
	localparam logic [2:0] ST_PUT  = 3'd5;

	// Control state.
	logic [2:0]            state_q;
	logic [1:0]            open_q;
	logic [GRANT_W-1:0]    remain_q;
	logic [SUM_W-1:0]      total_q;
	logic [ST_ENTRIES-1:0] valid_q;
	logic                  m_valid_q;

	// Configuration.
	logic [CAP_W-1:0]  cap_q [0:NUM_STRATA-1];
	logic [FRAC_W-1:0] frac_q;

	// Accepted word.
	logic               req_q;
	logic [1:0]         sel_q;
	logic [GRANT_W-1:0] offered_q;
	logic [WORD_W-1:0]  stamp_q;
	logic [WORD_W-1:0]  goal_q [0:IN_GOALS-1];
	logic [WORD_W-1:0]  value_q;
	logic               present_q;

	// Stage registers.
	strat_ent_t         ent_s1;
	logic [34:0]        prod_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [CAP_W-1:0]   cnt_s1;
	logic [SUM_W-1:0]   q_s2;

	// Result holding and output registers.
	res_t               res_q;
	res_t               out_res_q;
	logic [CAP_W-1:0]   out_bank_q;

	// State memory signals.
	logic               st_we;
	logic [ST_AW-1:0]   st_raddr;
	strat_ent_t         st_wdata;
	strat_ent_t         st_rdata;
	strat_ent_t         ent;

	// Datapath signals.
	logic               accept;
	logic               out_free;
	logic [1:0]         cur_s;
	logic [CAP_W-1:0]   effc [0:NUM_STRATA-1];
	logic [CAP_W-1:0]   cap_c;
	logic [SUM_W-1:0]   off_c;
	logic               live;
	logic [CUR_W-1:0]   pos;
	logic [CAP_W-1:0]   pos1;
	logic [CUR_W-1:0]   new_cursor;
	logic [SUM_W-1:0]   cnt1;
	logic [CAP_W-1:0]   new_count;
	logic [35:0]        quota;
	logic [19:0]        whole;
	logic [GRANT_W-1:0] grant;
	logic [35:0]        rest;
	logic [DEBT_W-1:0]  limit;
	logic [DEBT_W-1:0]  debt_new;
	logic [43:0]        recip_prod;
	logic [29:0]        rem_w;
	logic [SUM_W-1:0]   slot12;
	logic [WORD_W-1:0]  val_clean;
	logic [ROW_W-1:0]   row;
	logic               row_we;
	logic [CAP_W-1:0]   bank_sat;
	res_t               fin;
	logic               fin_go;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, out_bank_q, out_res_q};

	// Effective capacities and stratum offsets.
	always_comb begin
		for (int i = 0; i < NUM_STRATA; i++) begin
			effc[i] = eff_cap(cap_q[i]);
		end
	end

	assign cur_s = (req_q == REQ_OPEN) ? sel_q : open_q;

	always_comb begin
		case (cur_s)
			2'd0: begin
				cap_c = effc[0];
				off_c = '0;
			end
			2'd1: begin
				cap_c = effc[1];
				off_c = SUM_W'(effc[0]);
			end
			2'd2: begin
				cap_c = effc[2];
				off_c = SUM_W'(effc[0]) + SUM_W'(effc[1]);
			end
			default: begin
				cap_c = 11'd1;
				off_c = '0;
			end
		endcase
	end

	// Per-stratum state memory; an entry never written reads as zero.
	assign st_raddr = (s_axis_tuser == REQ_OPEN) ?
		s_axis_tdata[IN_SEL_LSB +: 2] : open_q;

	srb_ram #(
		.WIDTH($bits(strat_ent_t)),
		.DEPTH(ST_ENTRIES)
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(cur_s),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	assign ent = valid_q[cur_s] ? st_rdata : '0;

	// Candidate cursor and count update.
	assign live       = (cur_s != STRATUM_NONE) && (remain_q != '0);
	assign pos        = ({1'b0, ent.cursor} < cap_c) ? ent.cursor : '0;
	assign pos1       = {1'b0, pos} + 11'd1;
	assign new_cursor = (pos1 >= cap_c) ? '0 : pos1[CUR_W-1:0];
	assign cnt1       = {1'b0, ent.count} + 12'd1;
	assign new_count  = (cnt1 >= {1'b0, cap_c}) ? cap_c : cnt1[CAP_W-1:0];

	// Quota, grant and debt of an open.
	assign quota    = 36'(prod_s1) + 36'(ent_s1.debt);
	assign whole    = quota[35:16];
	assign grant    = (whole < {4'd0, offered_q}) ? whole[GRANT_W-1:0] : offered_q;
	assign rest     = quota - {4'd0, grant, 16'd0};
	assign limit    = {cap_c, 16'd0};
	assign debt_new = (rest < 36'(limit)) ? rest[DEBT_W-1:0] : limit;

	// Slot address reduction: quotient by reciprocal, then the remainder.
	assign recip_prod = 44'(sum_s1) * 44'(RECIP);
	assign rem_w      = 30'(sum_s1) - (30'(q_s2) * 30'(BANK_SIZE));
	assign slot12     = rem_w[SUM_W-1:0];

	// Value sanitizing: absent, NaN or infinite values become zero.
	assign val_clean = (!present_q || (value_q[30:23] == 8'hFF)) ? '0 : value_q;

	// Slot row: goal words, value, iteration stamp.
	genvar gw;
	for (gw = 0; gw < GOAL_WORDS; gw++) begin : g_row
		if (gw < IN_GOALS) begin : g_in
			assign row[gw*WORD_W +: WORD_W] = goal_q[gw];
		end else begin : g_zero
			assign row[gw*WORD_W +: WORD_W] = '0;
		end
	end
	assign row[GOAL_WORDS*WORD_W +: WORD_W]       = val_clean;
	assign row[(GOAL_WORDS+1)*WORD_W +: WORD_W]   = stamp_q;
	assign row_we = (state_q == ST_SLOT);

	srb_ram #(
		.WIDTH(ROW_W),
		.DEPTH(BANK_SIZE)
	) u_slot_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(AW'(slot12)),
		.wdata(row),
		.raddr('0),
		.rdata()
	);

	// State writes: candidate update in the read stage, debt update on open.
	always_comb begin
		st_we    = 1'b0;
		st_wdata = ent_s1;
		case (state_q)
			ST_READ: begin
				st_we           = (req_q == REQ_CAND) && live;
				st_wdata.debt   = ent.debt;
				st_wdata.count  = new_count;
				st_wdata.cursor = new_cursor;
			end
			ST_OPEN: begin
				st_we         = 1'b1;
				st_wdata.debt = debt_new;
			end
			default: begin
				st_we = 1'b0;
			end
		endcase
	end

	// Finished result of the current word.
	always_comb begin
		fin    = '0;
		fin_go = 1'b0;
		case (state_q)
			ST_READ: begin
				if (req_q == REQ_OPEN) begin
					fin_go = (sel_q == STRATUM_NONE);
				end else if (!live) begin
					fin_go = 1'b1;
					if (cur_s != STRATUM_NONE) begin
						fin.sfill = ent.count;
					end
				end
			end
			ST_OPEN: begin
				fin_go      = 1'b1;
				fin.granted = grant;
				fin.sfill   = ent_s1.count;
			end
			ST_SLOT: begin
				fin_go      = 1'b1;
				fin.written = 1'b1;
				fin.slot    = SLOT_W'(slot12);
				fin.stored  = val_clean;
				fin.sfill   = cnt_s1;
			end
			default: begin
				fin_go = 1'b0;
			end
		endcase
	end

	assign bank_sat = total_q[SUM_W-1] ? '1 : total_q[CAP_W-1:0];

	// Control registers and sequencing.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			open_q    <= '0;
			remain_q  <= '0;
			total_q   <= '0;
			valid_q   <= '0;
			m_valid_q <= 1'b0;
			cap_q[0]  <= 11'd256;
			cap_q[1]  <= 11'd256;
			cap_q[2]  <= 11'd512;
			frac_q    <= 24'd6554;
		end else begin
			// Configuration writes.
			if (cfg_we) begin
				case (cfg_addr)
					CFG_CAP_OFF: cap_q[0] <= cfg_data[CAP_W-1:0];
					CFG_CAP_DEF: cap_q[1] <= cfg_data[CAP_W-1:0];
					CFG_CAP_RES: cap_q[2] <= cfg_data[CAP_W-1:0];
					CFG_FRAC:    frac_q   <= cfg_data;
					default:     frac_q   <= frac_q;
				endcase
			end

			if (st_we) begin
				valid_q[cur_s] <= 1'b1;
			end

			// Output register handshake.
			if ((fin_go || (state_q == ST_PUT)) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					if (req_q == REQ_OPEN) begin
						open_q   <= sel_q;
						remain_q <= '0;
						if (sel_q != STRATUM_NONE) begin
							state_q <= ST_OPEN;
						end
					end else if (live) begin
						remain_q <= remain_q - 16'd1;
						total_q  <= total_q + SUM_W'(new_count) - SUM_W'(ent.count);
						state_q  <= ST_QUOT;
					end
					if (fin_go) begin
						state_q <= out_free ? ST_IDLE : ST_PUT;
					end
				end
				ST_OPEN: begin
					remain_q <= grant;
					state_q  <= out_free ? ST_IDLE : ST_PUT;
				end
				ST_QUOT: begin
					state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					state_q <= out_free ? ST_IDLE : ST_PUT;
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload and stage registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= s_axis_tuser;
			sel_q     <= s_axis_tdata[IN_SEL_LSB +: 2];
			offered_q <= s_axis_tdata[IN_OFFER_LSB +: GRANT_W];
			stamp_q   <= s_axis_tdata[IN_STAMP_LSB +: WORD_W];
			value_q   <= s_axis_tdata[IN_VAL_LSB +: WORD_W];
			present_q <= s_axis_tdata[IN_PRES_BIT];
			for (int w = 0; w < IN_GOALS; w++) begin
				goal_q[w] <= s_axis_tdata[IN_GOAL_LSB + w*WORD_W +: WORD_W];
			end
		end

		// Read stage: capture the entry, the quota product and the slot sum.
		if (state_q == ST_READ) begin
			ent_s1  <= ent;
			prod_s1 <= 35'(frac_q) * 35'(cap_c);
			sum_s1  <= off_c + SUM_W'(pos);
			cnt_s1  <= new_count;
		end

		// Quotient stage.
		if (state_q == ST_QUOT) begin
			q_s2 <= recip_prod[43:32];
		end

		// Result holding and output load.
		if (fin_go) begin
			if (out_free) begin
				out_res_q  <= fin;
				out_bank_q <= bank_sat;
			end else begin
				res_q <= fin;
			end
		end else if ((state_q == ST_PUT) && out_free) begin
			out_res_q  <= res_q;
			out_bank_q <= bank_sat;
		end
	end

endmodule

[hdl/srb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module srb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stratified ring bank refresh block. A short
// table of directed words runs first, then random refresh runs under several
// capacity and refresh fraction settings. Every result word is compared field
// by field with the table's expected word or a behavioral prediction of the
// bank, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module testbench;
	import srb_pkg::*;

	localparam int BANK_SLOTS = 1024;
	localparam int IDLE_LIMIT = 1000;
	localparam int RAND_WORDS = 1000;

	// One input word as the bench sees it, packed in tdata order.
	typedef struct packed {
		logic                             req;
		logic                             pres;
		logic [WORD_W-1:0]                value;
		logic [IN_GOALS-1:0][WORD_W-1:0]  goal;
		logic [WORD_W-1:0]                stamp;
		logic [GRANT_W-1:0]               offered;
		logic [1:0]                       sel;
	} item_t;

	// One result word, packed in tdata order.
	typedef struct packed {
		logic [CAP_W-1:0]   bank_fill;
		logic [CAP_W-1:0]   strat_fill;
		logic [WORD_W-1:0]  stored;
		logic [SLOT_W-1:0]  slot;
		logic               written;
		logic [GRANT_W-1:0] granted;
	} rsp_t;

	// One row of the directed part; want is used only where typed is set.
	typedef struct packed {
		item_t it;
		logic  typed;
		rsp_t  want;
	} row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_we = 1'b0;
	logic [1:0]             cfg_addr = '0;
	logic [FRAC_W-1:0]      cfg_data = '0;

	// Predicted bank state and its register copies, at their reset values.
	logic [CAP_W-1:0]  cap_reg [3] = '{11'd256, 11'd256, 11'd512};
	logic [FRAC_W-1:0] frac_reg = 24'd6554;
	int unsigned       ring_cursor [3] = '{0, 0, 0};
	int unsigned       ring_fill [3] = '{0, 0, 0};
	longint unsigned   ring_debt [3] = '{0, 0, 0};
	logic [1:0]        open_sel = '0;
	int unsigned       grant_left = 0;

	rsp_t pending_results [$];
	row_t dir_rows [$];
	rsp_t got_word;
	rsp_t want_word;
	int   mismatches = 0;
	int   words_sent = 0;
	int   results_seen = 0;
	int   slot_writes = 0;
	int   settings_used = 1;
	int   quiet_cycles = 0;
	bit   tx_burst = 1'b0;
	bit   rx_burst = 1'b0;

	stratified_ring_bank_refresh u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_tdata),
		.s_axis_tuser  (s_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Capacity as the block uses it: zero means one, large values clip.
	function automatic int unsigned usable_cap(input int s);
		int unsigned c;
		c = cap_reg[s];
		if (c == 0) begin
			return 1;
		end
		if (c > 1024) begin
			return 1024;
		end
		return c;
	endfunction

	// Advance the predicted bank by one accepted word and return its result.
	function automatic rsp_t bank_outcome(input item_t it);
		rsp_t            r;
		int              s;
		int unsigned     cap, pos, offs, slot_no, total;
		longint unsigned quota, whole, gr, rest, ceiling;
		logic [WORD_W-1:0] v;
		r = '0;
		if (it.req == REQ_OPEN) begin
			open_sel = it.sel;
			grant_left = 0;
			if (it.sel != STRATUM_NONE) begin
				s = it.sel;
				cap = usable_cap(s);
				quota = frac_reg;
				quota = quota * cap + ring_debt[s];
				whole = quota >> 16;
				gr = (whole < it.offered) ? whole : it.offered;
				rest = quota - (gr << 16);
				ceiling = cap;
				ceiling = ceiling << 16;
				ring_debt[s] = (rest < ceiling) ? rest : ceiling;
				grant_left = 32'(gr);
				r.granted = gr[15:0];
				r.strat_fill = 11'(ring_fill[s]);
			end
		end else if (open_sel != STRATUM_NONE) begin
			s = open_sel;
			if (grant_left != 0) begin
				cap = usable_cap(s);
				pos = (ring_cursor[s] < cap) ? ring_cursor[s] : 0;
				offs = 0;
				for (int k = 0; k < s; k++) begin
					offs += usable_cap(k);
				end
				slot_no = (offs + pos) % BANK_SLOTS;
				// NaN, infinity and a missing value are stored as zero.
				v = (!it.pres || it.value[30:23] == 8'hFF) ? '0 : it.value;
				ring_cursor[s] = (pos + 1 >= cap) ? 0 : pos + 1;
				ring_fill[s] = (ring_fill[s] + 1 >= cap) ? cap : ring_fill[s] + 1;
				grant_left--;
				r.written = 1'b1;
				r.slot = slot_no[9:0];
				r.stored = v;
			end
			r.strat_fill = 11'(ring_fill[s]);
		end
		total = ring_fill[0] + ring_fill[1] + ring_fill[2];
		r.bank_fill = (total > 2047) ? 11'd2047 : total[10:0];
		return r;
	endfunction

	function automatic item_t mk_open(input logic [1:0] sel, input logic [15:0] offered);
		item_t it;
		it = '0;
		it.req = REQ_OPEN;
		it.sel = sel;
		it.offered = offered;
		return it;
	endfunction

	function automatic item_t mk_cand(input logic [31:0] stamp, input logic [31:0] goal_fill,
			input logic [31:0] value, input logic pres);
		item_t it;
		it = '0;
		it.req = REQ_CAND;
		it.stamp = stamp;
		it.goal = {IN_GOALS{goal_fill}};
		it.value = value;
		it.pres = pres;
		return it;
	endfunction

	function automatic rsp_t result_of(input logic [15:0] granted, input logic written,
			input logic [9:0] slot, input logic [31:0] stored, input logic [10:0] sfill,
			input logic [10:0] bfill);
		rsp_t r;
		r.granted = granted;
		r.written = written;
		r.slot = slot;
		r.stored = stored;
		r.strat_fill = sfill;
		r.bank_fill = bfill;
		return r;
	endfunction

	function automatic void add_row(input item_t it, input logic typed, input rsp_t want);
		row_t r;
		r.it = it;
		r.typed = typed;
		r.want = want;
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// Value bits with a bias toward NaN, infinity and signed zero.
	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 7))
			0: begin
				v[30:23] = 8'hFF;
			end
			1: begin
				v[30:0] = '0;
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	function automatic item_t rand_cand();
		item_t it;
		it.req = REQ_CAND;
		it.sel = 2'($urandom_range(0, 3));
		it.offered = 16'($urandom_range(0, 65535));
		it.stamp = $urandom;
		for (int w = 0; w < IN_GOALS; w++) begin
			it.goal[w] = $urandom;
		end
		it.value = rand_value();
		it.pres = ($urandom_range(0, 5) != 0);
		return it;
	endfunction

	// Mostly small offers so that grants run out, now and then a full range one.
	function automatic item_t rand_open();
		item_t it;
		it = rand_cand();
		it.req = REQ_OPEN;
		it.sel = ($urandom_range(0, 15) == 0) ? STRATUM_NONE : 2'($urandom_range(0, 2));
		case ($urandom_range(0, 9))
			0, 1: begin
				it.offered = 16'($urandom_range(0, 65535));
			end
			2: begin
				it.offered = 16'($urandom_range(0, 300));
			end
			default: begin
				it.offered = 16'($urandom_range(0, 24));
			end
		endcase
		return it;
	endfunction

	// Send one word after a random gap and record what it should produce.
	task automatic offer_word(input item_t it, input logic typed, input rsp_t want);
		int   gap;
		rsp_t r;
		if ($urandom_range(0, 39) == 0) begin
			tx_burst = !tx_burst;
		end
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.req;
		s_tdata <= {5'd0, it.pres, it.value, it.goal, it.stamp, it.offered, it.sel};
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		r = bank_outcome(it);
		pending_results.insert(pending_results.size(), typed ? want : r);
		words_sent++;
	endtask

	// Let every expected word come out, then give the pipeline time to empty.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// Write all four registers back to back while the block is idle.
	task automatic program_bank(input logic [10:0] c0, input logic [10:0] c1,
			input logic [10:0] c2, input logic [23:0] frac);
		logic [1:0]  regs [4];
		logic [23:0] vals [4];
		regs = '{CFG_CAP_OFF, CFG_CAP_DEF, CFG_CAP_RES, CFG_FRAC};
		vals = '{{13'd0, c0}, {13'd0, c1}, {13'd0, c2}, frac};
		cfg_we <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_addr <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cap_reg[0] = c0;
		cap_reg[1] = c1;
		cap_reg[2] = c2;
		frac_reg = frac;
		settings_used++;
	endtask

	// Refresh runs: an open followed by a burst of candidates, plus some noise.
	task automatic random_traffic(input int n);
		int sent;
		int run_len;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 9) < 8) begin
				offer_word(rand_open(), 1'b0, '0);
				run_len = $urandom_range(0, 30);
				for (int i = 0; i < run_len; i++) begin
					offer_word(rand_cand(), 1'b0, '0);
				end
				sent += 1 + run_len;
			end else begin
				offer_word(rand_cand(), 1'b0, '0);
				sent++;
			end
		end
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// Result side: random back-pressure with stretches of none.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				rx_burst = !rx_burst;
			end
			gap = rx_burst ? 0 : $urandom_range(0, 13);
			if (gap != 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) begin
				@(posedge clk);
			end
		end
	end

	// Compare each accepted result word with the oldest prediction.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_tready) begin
			got_word = m_axis_tdata[$bits(rsp_t)-1:0];
			results_seen++;
			if (got_word.written) begin
				slot_writes++;
			end
			if (pending_results.size() == 0) begin
				$error("result word %h arrived with nothing expected", got_word);
				mismatches++;
			end else begin
				want_word = pending_results.pop_front();
				check_field("granted", want_word.granted, got_word.granted);
				check_field("written", want_word.written, got_word.written);
				check_field("slot_index", want_word.slot, got_word.slot);
				check_field("stored_value", want_word.stored, got_word.stored);
				check_field("stratum_fill", want_word.strat_fill, got_word.strat_fill);
				check_field("bank_fill", want_word.bank_fill, got_word.bank_fill);
			end
		end
	end

	// Watchdog on cycles in which nothing moves.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("watchdog expired with %0d results outstanding",
					pending_results.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Stimulus.
	initial begin
		// Directed rows on the reset configuration.
		add_row(mk_cand(32'h0, 32'h0, 32'h3F80_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b0, 10'd0, 32'h0, 11'd0, 11'd0));
		add_row(mk_open(STRATUM_NONE, 16'hFFFF), 1'b1,
			result_of(16'd0, 1'b0, 10'd0, 32'h0, 11'd0, 11'd0));
		add_row(mk_cand(32'h1, 32'h1, 32'h3F80_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b0, 10'd0, 32'h0, 11'd0, 11'd0));
		add_row(mk_open(2'd0, 16'd100), 1'b1,
			result_of(16'd25, 1'b0, 10'd0, 32'h0, 11'd0, 11'd0));
		add_row(mk_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h3F80_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b1, 10'd0, 32'h3F80_0000, 11'd1, 11'd1));
		// Quiet NaN, negative infinity, minus zero, missing value, largest finite.
		add_row(mk_cand(32'h2, 32'h5555_5555, 32'h7FC0_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b1, 10'd1, 32'h0, 11'd2, 11'd2));
		add_row(mk_cand(32'h3, 32'hAAAA_AAAA, 32'hFF80_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b1, 10'd2, 32'h0, 11'd3, 11'd3));
		add_row(mk_cand(32'h4, 32'h0, 32'h8000_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b1, 10'd3, 32'h8000_0000, 11'd4, 11'd4));
		add_row(mk_cand(32'h5, 32'h0, 32'h1234_5678, 1'b0), 1'b1,
			result_of(16'd0, 1'b1, 10'd4, 32'h0, 11'd5, 11'd5));
		add_row(mk_cand(32'h6, 32'h0, 32'h7F7F_FFFF, 1'b1), 1'b1,
			result_of(16'd0, 1'b1, 10'd5, 32'h7F7F_FFFF, 11'd6, 11'd6));
		add_row(mk_cand(32'h7, 32'h0, 32'h0000_0001, 1'b1), 1'b0, '0);
		// Zero offer builds debt; a candidate after it is dropped.
		add_row(mk_open(2'd1, 16'd0), 1'b1,
			result_of(16'd0, 1'b0, 10'd0, 32'h0, 11'd0, 11'd7));
		add_row(mk_cand(32'h8, 32'h0, 32'h4000_0000, 1'b1), 1'b1,
			result_of(16'd0, 1'b0, 10'd0, 32'h0, 11'd0, 11'd7));
		add_row(mk_open(2'd1, 16'hFFFF), 1'b0, '0);
		add_row(mk_cand(32'h9, 32'h0, 32'h4000_0000, 1'b1), 1'b0, '0);
		add_row(mk_cand(32'h0, 32'h0, 32'h0, 1'b1), 1'b0, '0);
		// Resource stratum: grant of two, then a dropped candidate.
		add_row(mk_open(2'd2, 16'd2), 1'b0, '0);
		add_row(mk_cand(32'hA, 32'h0, 32'hBF80_0000, 1'b1), 1'b0, '0);
		add_row(mk_cand(32'hB, 32'h0, 32'hBF80_0000, 1'b1), 1'b0, '0);
		add_row(mk_cand(32'hC, 32'h0, 32'hBF80_0000, 1'b1), 1'b0, '0);
		// A second open while grant is left over discards the rest.
		add_row(mk_open(2'd0, 16'd1), 1'b0, '0);
		add_row(mk_open(2'd0, 16'd3), 1'b0, '0);
		add_row(mk_cand(32'hD, 32'h0, 32'h3F00_0000, 1'b1), 1'b0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			offer_word(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);
		end
		random_traffic(RAND_WORDS / 8);

		// Smallest strata with the largest fraction: cursors restart at zero.
		settle();
		program_bank(11'd1, 11'd1, 11'd1, 24'hFF_FFFF);
		random_traffic(RAND_WORDS / 8);

		// Zero and oversized capacities overlap in the bank; no new quota.
		settle();
		program_bank(11'd0, 11'd2047, 11'd1024, 24'h0);
		random_traffic(RAND_WORDS / 16);

		settle();
		program_bank(11'd1024, 11'd1024, 11'd1024, 24'h01_0000);
		random_traffic(RAND_WORDS / 8);

		// Strata at the top of the bank and across its end.
		settle();
		program_bank(11'd1023, 11'd1, 11'd17, 24'h00_8000);
		random_traffic(RAND_WORDS / 8);

		for (int p = 0; p < 2; p++) begin
			settle();
			program_bank(11'($urandom_range(1, 12)), 11'($urandom_range(1, 12)),
				11'($urandom_range(1, 12)), 24'($urandom_range(0, 24'h03_0000)));
			random_traffic(RAND_WORDS / 8);
		end

		settle();
		program_bank(11'($urandom_range(1, 1024)), 11'($urandom_range(1, 1024)),
			11'($urandom_range(1, 1024)), 24'($urandom_range(0, 24'hFF_FFFF)));
		random_traffic(RAND_WORDS / 8);

		settle();
		$display("%0d words sent under %0d register settings", words_sent, settings_used);
		$display("%0d result words checked, %0d of them slot writes", results_seen, slot_writes);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
